FILE: rtl/hslca_pkg.sv
// shared constants, types and helpers for the hsl pixel color adjust block
package hslca_pkg;

  // unit level: 1.0 is 255 * 2^16
  localparam logic [23:0] ONE_LEVEL  = 24'd16711680;
  localparam logic [23:0] HALF_LEVEL = 24'd8355840;

  // hue in units of 2^-16 of 1/64 degree
  localparam logic [30:0] HUE_CIRCLE = 31'd1509949440;
  localparam logic [30:0] HUE_60     = 31'd251658240;
  localparam logic [30:0] HUE_120    = 31'd503316480;
  localparam logic [30:0] HUE_180    = 31'd754974720;
  localparam logic [30:0] HUE_240    = 31'd1006632960;

  // divider depths: saturation quotient and hue quotient bits
  localparam int unsigned SAT_STEPS = 24;
  localparam int unsigned HUE_STEPS = 28;

  // total register stages from input to output
  localparam int unsigned PIPE_DEPTH = 3 + HUE_STEPS + 9;

  // reciprocals for exact unsigned division of 32-bit values
  localparam logic [31:0] RCP_255 = 32'h80808081;  // x/255 = (x*m) >> 39
  localparam logic [31:0] RCP_15  = 32'h88888889;  // x/15  = (x*m) >> 35

  typedef enum logic [1:0] {
    REG_HUE_OFFSET,
    REG_SAT_RATIO,
    REG_LIG_RATIO,
    REG_ADJUST_MODE
  } reg_addr_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef enum logic [1:0] {
    RAMP_UP,
    RAMP_HI,
    RAMP_DOWN,
    RAMP_LO
  } ramp_sel_t;

  // one divider stage: both quotients shift in beside the remaining dividend bits
  typedef struct packed {
    logic [7:0]  sat_rem;
    logic [23:0] sat_qd;
    logic [7:0]  den;
    logic [7:0]  hue_rem;
    logic [27:0] hue_qd;
    logic [7:0]  dvs;
    sector_t     sector;
    logic        neg;
    logic        gray;
    logic [23:0] lig;
  } div_t;

endpackage

FILE: rtl/hsl_pixel_color_adjust_top.sv
// top level: rgb to hsl, hue/saturation/lightness adjust, hsl back to rgb
// throughput: one pixel per cycle; the whole pipeline advances together and
//   holds while a result waits on the master side
// the two restoring dividers take one quotient bit per stage (28 stages)
// reset: synchronous, clears all stage valid bits and the config registers
module hsl_pixel_color_adjust_top (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // pixel in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // blue_in, green_in, red_in (red in bits 7:0)
  // pixel out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // blue_out, green_out, red_out (red in bits 7:0)
);
  import hslca_pkg::*;

  // config registers
  logic [14:0]        hue_offset;
  logic signed [16:0] sat_ratio;
  logic signed [16:0] lig_ratio;
  logic               adjust_mode;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_offset  <= '0;
      sat_ratio   <= '0;
      lig_ratio   <= '0;
      adjust_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_addr_t'(paddr[3:2]))
        REG_HUE_OFFSET:  hue_offset  <= pwdata[14:0];
        REG_SAT_RATIO:   sat_ratio   <= pwdata[16:0];
        REG_LIG_RATIO:   lig_ratio   <= pwdata[16:0];
        REG_ADJUST_MODE: adjust_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (reg_addr_t'(paddr[3:2]))
      REG_HUE_OFFSET:  prdata = {17'd0, hue_offset};
      REG_SAT_RATIO:   prdata = {{15{sat_ratio[16]}}, sat_ratio};
      REG_LIG_RATIO:   prdata = {{15{lig_ratio[16]}}, lig_ratio};
      REG_ADJUST_MODE: prdata = {31'd0, adjust_mode};
      default:         prdata = '0;
    endcase
  end

  // pipeline advance and valid bits
  logic                  en;
  logic [PIPE_DEPTH-1:0] vld;

  assign en            = !vld[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  // helpers
  function automatic div_t div_step(div_t x, logic do_sat);
    logic [8:0] ts;
    logic [8:0] th;
    div_t       y;
    y  = x;
    ts = {x.sat_rem, x.sat_qd[23]};
    th = {x.hue_rem, x.hue_qd[27]};
    if (do_sat) begin
      if (ts >= {1'b0, x.den}) begin
        y.sat_rem = 8'(ts - {1'b0, x.den});
        y.sat_qd  = {x.sat_qd[22:0], 1'b1};
      end else begin
        y.sat_rem = ts[7:0];
        y.sat_qd  = {x.sat_qd[22:0], 1'b0};
      end
    end
    if (th >= {1'b0, x.dvs}) begin
      y.hue_rem = 8'(th - {1'b0, x.dvs});
      y.hue_qd  = {x.hue_qd[26:0], 1'b1};
    end else begin
      y.hue_rem = th[7:0];
      y.hue_qd  = {x.hue_qd[26:0], 1'b0};
    end
    return y;
  endfunction

  // ratio product: top bit is the positive-ratio flag
  function automatic logic [41:0] scale_mul(logic [23:0] x, logic [16:0] r);
    logic        pos;
    logic [16:0] mag;
    logic [23:0] f;
    pos = !r[16] && (r != 17'd0);
    mag = pos ? {1'b0, r[15:0]} : 17'(~r + 17'd1);
    f   = pos ? 24'(ONE_LEVEL - x) : x;
    return {pos, 41'(41'(f) * 41'(mag))};
  endfunction

  function automatic logic [23:0] scale_fin(logic [23:0] x, logic [41:0] pm, logic mode);
    logic [26:0] t;
    if (pm[41]) t = 27'(x) + 27'(pm[40:15]);
    else        t = 27'(pm[40:15]);
    if (!mode)                 return x;
    else if (t > 27'(ONE_LEVEL)) return ONE_LEVEL;
    else                       return t[23:0];
  endfunction

  function automatic logic [29:0] ramp_pick(logic [30:0] h);
    if (h < HUE_60)       return {RAMP_UP, h[27:0]};
    else if (h < HUE_180) return {RAMP_HI, 28'd0};
    else if (h < HUE_240) return {RAMP_DOWN, 28'(HUE_240 - h)};
    else                  return {RAMP_LO, 28'd0};
  endfunction

  function automatic logic [30:0] hue_wrap(logic [31:0] h);
    if (h >= 32'(HUE_CIRCLE)) return 31'(h - 32'(HUE_CIRCLE));
    else                      return h[30:0];
  endfunction

  // stage 0: input register
  logic [7:0] r0, g0, b0;
  always_ff @(posedge clk) begin
    if (en) {b0, g0, r0} <= s_axis_tdata;
  end

  // stage 1: max, min, sector and hue numerator
  logic [7:0] mx_c, mn_c, num_c;
  logic       neg_c;
  sector_t    sec_c;
  logic [7:0] mx1, mn1, num1;
  logic       neg1;
  sector_t    sec1;

  always_comb begin
    mx_c = r0;
    mn_c = r0;
    if (g0 > mx_c) mx_c = g0;
    if (b0 > mx_c) mx_c = b0;
    if (g0 < mn_c) mn_c = g0;
    if (b0 < mn_c) mn_c = b0;
    if (r0 == mx_c) begin
      sec_c = SEC_RED;
      neg_c = g0 < b0;
      num_c = neg_c ? 8'(b0 - g0) : 8'(g0 - b0);
    end else if (g0 == mx_c) begin
      sec_c = SEC_GREEN;
      neg_c = b0 < r0;
      num_c = neg_c ? 8'(r0 - b0) : 8'(b0 - r0);
    end else begin
      sec_c = SEC_BLUE;
      neg_c = r0 < g0;
      num_c = neg_c ? 8'(g0 - r0) : 8'(r0 - g0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1  <= mx_c;
      mn1  <= mn_c;
      num1 <= num_c;
      neg1 <= neg_c;
      sec1 <= sec_c;
    end
  end

  // stage 2: divider setup
  div_t dv [HUE_STEPS+1];
  logic [8:0]  sum_c;
  logic [7:0]  d_c, den_c;
  logic [15:0] satn_c;
  logic [19:0] huea_c;
  div_t        dv0_c;

  always_comb begin
    sum_c  = 9'(mx1) + 9'(mn1);
    d_c    = 8'(mx1 - mn1);
    den_c  = (sum_c <= 9'd255) ? sum_c[7:0] : 8'(9'd510 - sum_c);
    satn_c = 16'(16'(d_c) * 16'd255);
    huea_c = 20'(20'(num1) * 20'd3840);
    dv0_c.sat_rem = satn_c[15:8];
    dv0_c.sat_qd  = {satn_c[7:0], 16'd0};
    dv0_c.den     = (d_c == 8'd0) ? 8'd1 : den_c;
    dv0_c.hue_rem = huea_c[19:12];
    dv0_c.hue_qd  = {huea_c[11:0], 16'd0};
    dv0_c.dvs     = (d_c == 8'd0) ? 8'd1 : d_c;
    dv0_c.sector  = sec1;
    dv0_c.neg     = neg1;
    dv0_c.gray    = (d_c == 8'd0);
    dv0_c.lig     = {sum_c, 15'd0};
  end

  always_ff @(posedge clk) begin
    if (en) dv[0] <= dv0_c;
  end

  // divider stages, one quotient bit each
  for (genvar k = 0; k < HUE_STEPS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) dv[k+1] <= div_step(dv[k], 1'(k < SAT_STEPS));
    end
  end

  // p1: signed hue from sector and quotient, gray pixels forced
  div_t        dl;
  logic [30:0] base_c, hue0_c;
  logic [30:0] p1_hue;
  logic [23:0] p1_sat, p1_lig;

  assign dl = dv[HUE_STEPS];

  always_comb begin
    case (dl.sector)
      SEC_RED:   base_c = '0;
      SEC_GREEN: base_c = HUE_120;
      SEC_BLUE:  base_c = HUE_240;
      default:   base_c = '0;
    endcase
    if (dl.gray)                        hue0_c = '0;
    else if (!dl.neg)                   hue0_c = base_c + 31'(dl.hue_qd);
    else if (31'(dl.hue_qd) > base_c)   hue0_c = HUE_CIRCLE - (31'(dl.hue_qd) - base_c);
    else                                hue0_c = base_c - 31'(dl.hue_qd);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_hue <= hue0_c;
      p1_sat <= dl.gray ? 24'd0 : dl.sat_qd;
      p1_lig <= dl.lig;
    end
  end

  // p2: hue offset with first wrap, ratio products
  logic [30:0] p2_hue;
  logic [23:0] p2_sat, p2_lig;
  logic [41:0] p2_sp, p2_lp;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_hue <= hue_wrap(32'(p1_hue) + {1'b0, hue_offset, 16'd0});
      p2_sat <= p1_sat;
      p2_lig <= p1_lig;
      p2_sp  <= scale_mul(p1_sat, sat_ratio);
      p2_lp  <= scale_mul(p1_lig, lig_ratio);
    end
  end

  // p3: second hue wrap, scaled saturation and lightness
  logic [30:0] p3_hue;
  logic [23:0] p3_sat, p3_lig;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_hue <= hue_wrap(32'(p2_hue));
      p3_sat <= scale_fin(p2_sat, p2_sp, adjust_mode);
      p3_lig <= scale_fin(p2_lig, p2_lp, adjust_mode);
    end
  end

  // p4: channel hues, lightness times saturation
  logic [30:0] p4_h [3];
  logic [23:0] p4_sat, p4_lig;
  logic [47:0] p4_ls;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_h[0] <= hue_wrap(32'(p3_hue) + 32'(HUE_120));
      p4_h[1] <= p3_hue;
      p4_h[2] <= hue_wrap(32'(p3_hue) + 32'(HUE_240));
      p4_sat  <= p3_sat;
      p4_lig  <= p3_lig;
      p4_ls   <= 48'(p3_lig) * 48'(p3_sat);
    end
  end

  // p5: divide the product by 255 through its reciprocal
  logic [30:0] p5_h [3];
  logic [23:0] p5_sat, p5_lig;
  logic [63:0] p5_m;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_h   <= p4_h;
      p5_sat <= p4_sat;
      p5_lig <= p4_lig;
      p5_m   <= 64'(p4_ls[47:16]) * 64'(RCP_255);
    end
  end

  // p6: ramp levels and per-channel ramp selection
  logic [23:0] ls_c, rm2_c, rm1_c;
  logic [25:0] a_c, b_c;
  logic [29:0] pick_c [3];
  logic [23:0] p6_rm1, p6_rm2;
  ramp_sel_t   p6_sel [3];
  logic [27:0] p6_f [3];

  always_comb begin
    ls_c = p5_m[62:39];
    if (p5_lig <= HALF_LEVEL) a_c = 26'(p5_lig) + 26'(ls_c);
    else                      a_c = 26'(p5_lig) + 26'(p5_sat) - 26'(ls_c);
    rm2_c = (a_c > 26'(ONE_LEVEL)) ? ONE_LEVEL : a_c[23:0];
    b_c   = 26'({p5_lig, 1'b0}) - 26'(rm2_c);
    if (b_c[25])                     rm1_c = '0;
    else if (b_c[24:0] > 25'(rm2_c)) rm1_c = rm2_c;
    else                             rm1_c = b_c[23:0];
    for (int c = 0; c < 3; c++) pick_c[c] = ramp_pick(p5_h[c]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p6_rm1 <= rm1_c;
      p6_rm2 <= rm2_c;
      for (int c = 0; c < 3; c++) begin
        p6_sel[c] <= ramp_sel_t'(pick_c[c][29:28]);
        p6_f[c]   <= pick_c[c][27:0];
      end
    end
  end

  // p7: level span times hue position
  logic [23:0] dif_c;
  logic [23:0] p7_rm1, p7_rm2;
  ramp_sel_t   p7_sel [3];
  logic [51:0] p7_p [3];

  assign dif_c = p6_rm2 - p6_rm1;

  always_ff @(posedge clk) begin
    if (en) begin
      p7_rm1 <= p6_rm1;
      p7_rm2 <= p6_rm2;
      p7_sel <= p6_sel;
      for (int c = 0; c < 3; c++) p7_p[c] <= 52'(dif_c) * 52'(p6_f[c]);
    end
  end

  // p8: divide by 60 degrees (15 * 2^24) through a reciprocal
  logic [23:0] p8_rm1, p8_rm2;
  ramp_sel_t   p8_sel [3];
  logic [63:0] p8_m [3];

  always_ff @(posedge clk) begin
    if (en) begin
      p8_rm1 <= p7_rm1;
      p8_rm2 <= p7_rm2;
      p8_sel <= p7_sel;
      for (int c = 0; c < 3; c++) p8_m[c] <= 64'(p7_p[c][51:24]) * 64'(RCP_15);
    end
  end

  // p9: final channel level and output register
  logic [23:0] lvl_c [3];
  logic [7:0]  p9_ch [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (p8_sel[c])
        RAMP_UP, RAMP_DOWN: lvl_c[c] = p8_rm1 + p8_m[c][58:35];
        RAMP_HI:            lvl_c[c] = p8_rm2;
        RAMP_LO:            lvl_c[c] = p8_rm1;
        default:            lvl_c[c] = p8_rm1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) p9_ch[c] <= lvl_c[c][23:16];
    end
  end

  assign m_axis_tdata = {p9_ch[2], p9_ch[1], p9_ch[0]};

endmodule

FILE: rtl/hslca_check.sv
// port-level checks for the hsl pixel color adjust block, bound to the top level
module hslca_check (
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import hslca_pkg::*;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // input side only stalls while a result is waiting
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled without a waiting result");

  // hue offset reads back what was written
  a_hue_rd: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[3:2] == REG_HUE_OFFSET)
      |=> (paddr[3:2] != REG_HUE_OFFSET || prdata[14:0] == $past(pwdata[14:0])))
    else $error("hue offset readback mismatch");

endmodule

bind hsl_pixel_color_adjust_top hslca_check u_hslca_check (.*);
